// ===== hw/rtl/bgld_pkg.sv =====
package bgld_pkg;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_FLUSH = 2'd1,
    OP_CLEAR = 2'd2,
    OP_INIT  = 2'd3
  } op_t;

  localparam logic [3:0] BRIGHT_RESET = 4'd7;

  // last word index of each sequence
  localparam logic [4:0] FRAME_LAST = 5'd31;
  localparam logic [4:0] INIT_LAST  = 5'd19;

  // driver control registers
  localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
  localparam logic [3:0] REG_TEST      = 4'hF;
  localparam logic [3:0] REG_DECODE    = 4'h9;
  localparam logic [3:0] REG_SCANLIMIT = 4'hB;
  localparam logic [3:0] REG_INTENSITY = 4'hA;

  localparam logic [7:0] SHUTDOWN_RUN = 8'h01;
  localparam logic [7:0] SCAN_ALL     = 8'h07;

  typedef struct packed {
    logic       draw;
    logic       clear;
    logic       emit;
    logic       init_seq;
    logic [4:0] word_idx;
    logic       last;
  } ctrl_cmd_t;

  function automatic logic [3:0] init_addr(input logic [2:0] grp);
    logic [3:0] a;
    case (grp)
      3'd0:    a = REG_SHUTDOWN;
      3'd1:    a = REG_TEST;
      3'd2:    a = REG_DECODE;
      3'd3:    a = REG_SCANLIMIT;
      default: a = REG_INTENSITY;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] init_data(input logic [2:0] grp, input logic [3:0] bright);
    logic [7:0] d;
    case (grp)
      3'd0:    d = SHUTDOWN_RUN;
      3'd3:    d = SCAN_ALL;
      3'd4:    d = {4'd0, bright};
      default: d = 8'h00;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/bgld_ctrl.sv =====
module bgld_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  logic [1:0]            op,
  input  logic                  out_free,
  output bgld_pkg::ctrl_cmd_t   cmd
);
  import bgld_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       is_init, is_init_next;
  logic [4:0] last_idx;

  assign last_idx  = is_init ? INIT_LAST : FRAME_LAST;
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    is_init_next = is_init;
    cmd          = '0;
    cmd.word_idx = cnt;
    cmd.init_seq = is_init;
    cmd.last     = (cnt == last_idx);
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (op == OP_DRAW) begin
            cmd.draw = 1'b1;
          end else begin
            cmd.clear    = (op == OP_CLEAR);
            state_next   = S_EMIT;
            cnt_next     = '0;
            is_init_next = (op == OP_INIT);
          end
        end
      end
      S_EMIT: begin
        // advance only when the output register can take a word
        if (out_free) begin
          cmd.emit = 1'b1;
          if (cnt == last_idx) begin
            state_next = S_IDLE;
          end else begin
            cnt_next = cnt + 5'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      is_init <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      is_init <= is_init_next;
    end
  end

endmodule

// ===== hw/rtl/bgld_dp.sv =====
module bgld_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  bgld_pkg::ctrl_cmd_t   cmd,
  input  logic [3:0]            column,
  input  logic [7:0]            bar_height,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            brightness,
  output logic                  out_free,
  output logic                  word_valid,
  input  logic                  word_stall,
  output logic [3:0]            reg_addr,
  output logic [7:0]            reg_data,
  output logic                  latch_after,
  output logic                  last_word
);
  import bgld_pkg::*;

  // entry {module, row}: bit c lights local column c
  logic [7:0] frame [32];
  logic [3:0] bright_q;
  logic [4:0] rd_idx;
  logic [3:0] addr_w;
  logic [7:0] data_w;

  assign cfg_ready = 1'b1;
  assign out_free  = !word_valid || !word_stall;

  // module 3 first, then 2, 1, 0 within each row
  assign rd_idx = {~cmd.word_idx[1:0], cmd.word_idx[4:2]};

  always_comb begin
    if (cmd.init_seq) begin
      addr_w = init_addr(cmd.word_idx[4:2]);
      data_w = init_data(cmd.word_idx[4:2], bright_q);
    end else begin
      addr_w = {1'b0, cmd.word_idx[4:2]} + 4'd1;
      data_w = frame[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_q <= BRIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bright_q <= brightness;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < 32; i++) begin
        frame[i] <= '0;
      end
    end else if (cmd.draw) begin
      // bottom module holds the lowest eight pixels, top module the next eight
      for (int p = 0; p < 8; p++) begin
        frame[{1'b1, column[3], 3'(p)}][column[2:0]] <= (bar_height > 8'(p));
        frame[{1'b0, column[3], 3'(p)}][column[2:0]] <= (bar_height > 8'(p + 8));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (cmd.emit) begin
      word_valid <= 1'b1;
    end else if (!word_stall) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      reg_addr    <= addr_w;
      reg_data    <= data_w;
      latch_after <= (cmd.word_idx[1:0] == 2'b11);
      last_word   <= cmd.last;
    end
  end

endmodule

// ===== hw/rtl/bar_graph_led_matrix_driver.sv =====
// Bar-graph driver for a 16x16 display of four cascaded 8x8 LED driver modules.
// Command channel (cmd_valid/cmd_stall, op, column, bar_height):
//   draw  - redraw one column's bar in the frame store; emits nothing.
//   flush - emits 32 register words, row by row, farthest module first.
//   clear - zeroes the frame store, then emits the same 32 words as flush.
//   init  - emits the 20 setup words, intensity taken from brightness.
// Word channel (word_valid/word_stall): reg_addr, reg_data, latch_after marks
// every fourth word, last_word marks the final word of a request.
// A taken request is registered into the sequencer, which then loads each word
// into a single output register; words follow one a cycle while the word
// channel is not stalled, and the next request is taken only after the last word. The
// sequencer holds one request at a time; cmd_stall is high while it runs.
// A stall on the word channel holds the output word and freezes the sequencer.
// Configuration (cfg_valid/cfg_ready, brightness) is always ready.
// Reset clears the frame store, sets brightness to 7 and drops any word.
module bar_graph_led_matrix_driver (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [1:0] op,
  input  logic [3:0] column,
  input  logic [7:0] bar_height,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] brightness,
  output logic       word_valid,
  input  logic       word_stall,
  output logic [3:0] reg_addr,
  output logic [7:0] reg_data,
  output logic       latch_after,
  output logic       last_word
);
  import bgld_pkg::*;

  ctrl_cmd_t cmd;
  logic      out_free;

  bgld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .op        (op),
    .out_free  (out_free),
    .cmd       (cmd)
  );

  bgld_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .column      (column),
    .bar_height  (bar_height),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .brightness  (brightness),
    .out_free    (out_free),
    .word_valid  (word_valid),
    .word_stall  (word_stall),
    .reg_addr    (reg_addr),
    .reg_data    (reg_data),
    .latch_after (latch_after),
    .last_word   (last_word)
  );

endmodule

// ===== hw/rtl/bgld_checker.sv =====
module bgld_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_stall,
  input logic [1:0] op,
  input logic       word_valid,
  input logic       word_stall,
  input logic [3:0] reg_addr,
  input logic [7:0] reg_data,
  input logic       latch_after,
  input logic       last_word
);
  import bgld_pkg::*;

  // a stalled word holds
  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    word_valid && word_stall |=>
      word_valid && $stable(reg_addr) && $stable(reg_data) &&
      $stable(latch_after) && $stable(last_word))
    else $error("stalled word changed");

  // every word sequence ends on a latch boundary
  a_last_latch: assert property (@(posedge clk) disable iff (rst)
    word_valid && last_word |-> latch_after)
    else $error("last word without latch");

  a_addr_nonzero: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> reg_addr != 4'd0)
    else $error("no-op register address emitted");

  a_draw_quick: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && op == OP_DRAW |=> !cmd_stall)
    else $error("draw request blocked the next request");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && op != OP_DRAW |=> cmd_stall)
    else $error("word sequence did not start");

endmodule

bind bar_graph_led_matrix_driver bgld_checker u_bgld_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd_valid),
  .cmd_stall   (cmd_stall),
  .op          (op),
  .word_valid  (word_valid),
  .word_stall  (word_stall),
  .reg_addr    (reg_addr),
  .reg_data    (reg_data),
  .latch_after (latch_after),
  .last_word   (last_word)
);

// ===== bench/tb_bar_graph_led_matrix_driver.sv =====
`timescale 1ns / 1ps

module tb_bar_graph_led_matrix_driver;
  import bgld_pkg::*;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       latch;
    logic       last;
  } word_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] col;
    logic [7:0] height;
  } request_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  op_t        op = OP_DRAW;
  logic [3:0] column = 4'd0;
  logic [7:0] bar_height = 8'd0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] brightness = BRIGHT_RESET;
  logic       word_valid;
  logic       word_stall = 1'b0;
  logic [3:0] reg_addr;
  logic [7:0] reg_data;
  logic       latch_after;
  logic       last_word;

  // shadow of the block's frame store and intensity setting
  logic [7:0] frame_img [32];
  logic [3:0] model_bright = BRIGHT_RESET;

  request_t   request_queue [$];
  word_t      owed_words [$];
  int         errors = 0;

  int          burst_left = 0;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;

  bar_graph_led_matrix_driver dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .op         (op),
    .column     (column),
    .bar_height (bar_height),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .brightness (brightness),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .reg_addr   (reg_addr),
    .reg_data   (reg_data),
    .latch_after(latch_after),
    .last_word  (last_word)
  );

  always #5 clk = ~clk;

  task automatic push_word(input logic [3:0] a, input logic [7:0] d, input logic l,
                           input logic fin);
    word_t w;
    w.addr  = a;
    w.data  = d;
    w.latch = l;
    w.last  = fin;
    owed_words.push_back(w);
  endtask

  // Update the frame shadow and queue the words that one request produces.
  task automatic predict_words(input request_t r);
    logic [7:0] colbit;
    logic [3:0] a;
    logic [7:0] d;
    int top, bot, lim, p, row, m, g, i;
    case (r.op)
      OP_DRAW: begin
        colbit = 8'd1 << r.col[2:0];
        top = r.col[3] ? 1 : 0;
        bot = top + 2;
        lim = (r.height > 16) ? 16 : r.height;
        for (p = 0; p < 8; p++) begin
          frame_img[top * 8 + p] &= ~colbit;
          frame_img[bot * 8 + p] &= ~colbit;
        end
        // fill bottom module first, then carry into the top module
        for (p = 0; p < lim; p++) begin
          if (p < 8) frame_img[bot * 8 + p] |= colbit;
          else frame_img[top * 8 + p - 8] |= colbit;
        end
      end
      OP_FLUSH, OP_CLEAR: begin
        if (r.op == OP_CLEAR) begin
          for (p = 0; p < 32; p++) frame_img[p] = 8'd0;
        end
        for (row = 0; row < 8; row++) begin
          for (m = 0; m < 4; m++) begin
            push_word(4'(row + 1), frame_img[(3 - m) * 8 + row], m == 3,
                      row == 7 && m == 3);
          end
        end
      end
      default: begin
        for (g = 0; g < 5; g++) begin
          case (g)
            0:       begin a = REG_SHUTDOWN;  d = SHUTDOWN_RUN; end
            1:       begin a = REG_TEST;      d = 8'h00; end
            2:       begin a = REG_DECODE;    d = 8'h00; end
            3:       begin a = REG_SCANLIMIT; d = SCAN_ALL; end
            default: begin a = REG_INTENSITY; d = {4'd0, model_bright}; end
          endcase
          for (i = 0; i < 4; i++) push_word(a, d, i == 3, g == 4 && i == 3);
        end
      end
    endcase
  endtask

  task automatic queue_request(input op_t o, input logic [3:0] c, input logic [7:0] h);
    request_t r;
    r.op     = o;
    r.col    = c;
    r.height = h;
    request_queue.push_back(r);
  endtask

  // Mostly draws so that flushes carry a busy frame; heights lean toward 0..16.
  task automatic queue_random(input int count);
    int n, pick, hsel;
    op_t o;
    logic [7:0] h;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) o = OP_DRAW;
      else if (pick < 82) o = OP_FLUSH;
      else if (pick < 90) o = OP_CLEAR;
      else o = OP_INIT;
      hsel = $urandom_range(0, 9);
      if (hsel < 6) h = 8'($urandom_range(0, 16));
      else if (hsel < 9) h = 8'($urandom_range(17, 255));
      else h = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      queue_request(o, 4'($urandom_range(0, 15)), h);
    end
  endtask

  task automatic wait_idle();
    while (request_queue.size() != 0 || cmd_valid || owed_words.size() != 0) @(posedge clk);
    // let a trailing draw settle
    repeat (8) @(posedge clk);
  endtask

  task automatic write_brightness(input logic [3:0] v);
    @(posedge clk);
    cfg_valid  <= 1'b1;
    brightness <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_bright = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Request driver: bursts of requests separated by random gaps.
  always @(posedge clk) begin : request_driver
    logic     taken;
    request_t nxt;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      taken = cmd_valid && !cmd_stall;
      if (taken) predict_words('{op, column, bar_height});
      if (!cmd_valid || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          nxt = request_queue.pop_front();
          op         <= nxt.op;
          column     <= nxt.col;
          bar_height <= nxt.height;
          cmd_valid  <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(1, 3);
              2:       gap_left = $urandom_range(4, 12);
              default: gap_left = $urandom_range(13, 45);
            endcase
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Word monitor and receiver stall pattern.
  always @(posedge clk) begin : word_monitor
    word_t got, want;
    logic  hold;
    if (rst) begin
      word_stall <= 1'b0;
    end else begin
      if (word_valid && !word_stall) begin
        got = '{reg_addr, reg_data, latch_after, last_word};
        if (owed_words.size() == 0) begin
          errors++;
          $display({"%0t ns: unexpected word, expected none, ",
                    "actual addr %0h data %0h latch %b last %b"},
                   $time, got.addr, got.data, got.latch, got.last);
        end else begin
          want = owed_words.pop_front();
          check_field("reg_addr", 8'(want.addr), 8'(got.addr));
          check_field("reg_data", want.data, got.data);
          check_field("latch_after", 8'(want.latch), 8'(got.latch));
          check_field("last_word", 8'(want.last), 8'(got.last));
        end
      end
      if (mode_left <= 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  hold = 1'b0;
        STALL_LIGHT: hold = $urandom_range(0, 99) < 25;
        STALL_HEAVY: hold = $urandom_range(0, 99) < 70;
        default:     hold = ~word_stall;
      endcase
      word_stall <= hold;
    end
  end

  initial begin : sequencer
    int k;
    for (k = 0; k < 32; k++) frame_img[k] = 8'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset intensity, empty frame, height extremes, both halves
    queue_request(OP_INIT, 4'd0, 8'd0);
    queue_request(OP_FLUSH, 4'd15, 8'd255);
    queue_request(OP_DRAW, 4'd0, 8'd16);
    queue_request(OP_DRAW, 4'd15, 8'd255);
    queue_request(OP_DRAW, 4'd7, 8'd17);
    queue_request(OP_DRAW, 4'd8, 8'd8);
    queue_request(OP_DRAW, 4'd3, 8'd9);
    queue_request(OP_DRAW, 4'd12, 8'd1);
    queue_request(OP_DRAW, 4'd10, 8'd15);
    queue_request(OP_DRAW, 4'd4, 8'd7);
    queue_request(OP_FLUSH, 4'd0, 8'd0);
    queue_request(OP_DRAW, 4'd0, 8'd0);
    queue_request(OP_DRAW, 4'd15, 8'd3);
    queue_request(OP_FLUSH, 4'd5, 8'd170);
    queue_request(OP_CLEAR, 4'd9, 8'd85);
    queue_request(OP_FLUSH, 4'd0, 8'd0);
    queue_request(OP_DRAW, 4'd9, 8'd128);
    queue_request(OP_DRAW, 4'd1, 8'd16);
    queue_request(OP_DRAW, 4'd14, 8'd12);
    queue_request(OP_FLUSH, 4'd0, 8'd0);
    queue_request(OP_INIT, 4'd15, 8'd255);
    wait_idle();

    write_brightness(4'hF);
    queue_request(OP_INIT, 4'd0, 8'd0);
    queue_random(80);
    wait_idle();

    write_brightness(4'h0);
    queue_request(OP_INIT, 4'd0, 8'd0);
    queue_random(90);
    wait_idle();

    repeat (3) begin
      write_brightness(4'($urandom_range(0, 15)));
      queue_request(OP_INIT, 4'd0, 8'd0);
      queue_random(90);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bgld_pkg.sv
hw/rtl/bgld_ctrl.sv
hw/rtl/bgld_dp.sv
hw/rtl/bar_graph_led_matrix_driver.sv
hw/rtl/bgld_checker.sv
bench/tb_bar_graph_led_matrix_driver.sv
